// File: rtl/core/efd_pkg.sv
// shared types, marker codes, status codes and the crc-32 byte update
// for the escaped frame deframer; no dependencies
package efd_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [1:0]  t_status;
    typedef logic [31:0] t_crc;
    typedef logic [2:0]  t_fill;

    localparam t_byte MARK_START = 8'h53;
    localparam t_byte MARK_END   = 8'h45;
    localparam t_byte MARK_ESC   = 8'h40;

    localparam int    TRAILER_LEN = 4;
    localparam t_fill TRAILER_FULL = t_fill'(TRAILER_LEN);

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam t_status ST_GOOD    = 2'd0;
    localparam t_status ST_SHORT   = 2'd1;
    localparam t_status ST_BAD_CRC = 2'd2;

    localparam t_crc CRC_INIT = 32'hFFFF_FFFF;
    localparam t_crc CRC_POLY = 32'hEDB8_8320;

    // reflected crc-32, one byte, bitwise
    function automatic t_crc crc32_byte(input t_crc crc_in, input t_byte data);
        t_crc c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/efd_if.sv
// valid/ready stream interfaces for the raw byte input and the result output
// depends on efd_pkg
interface efd_in_if;
    logic           valid;
    logic           ready;
    efd_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efd_out_if;
    logic             valid;
    logic             ready;
    logic             out_kind;
    efd_pkg::t_byte   out_byte;
    efd_pkg::t_status frame_status;

    modport source (output valid, output out_kind, output out_byte, output frame_status,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input frame_status,
                    output ready);
endinterface

// File: rtl/core/escaped_frame_deframer_crc32.sv
// Escaped frame deframer with CRC-32 trailer check.
//
// i_rx carries one raw line byte per transaction. While hunting, two 'S'
// bytes in a row open a frame; inside a frame '@' makes the next byte a
// literal, an unescaped 'E' closes the frame and an unescaped 'S' closes it
// and counts as the first start byte of the next one. Decoded bytes pass a
// four-byte delay line; bytes leaving it come out on o_res as payload
// (out_kind 0) and feed the CRC. At frame end o_res gives one status
// transaction (out_kind 1): good, too short, or CRC mismatch against the
// little-endian trailer. Payload is sent before the check, so the receiver
// drops it on a bad status. Hunt bytes, opening start markers and escape markers give no transaction.
//
// Latency: a result appears on o_res the cycle after the byte that causes
// it. Throughput: one byte per cycle; i_rx.ready stays high while the output
// register is empty or being drained, so a stalled receiver holds at most one
// result and backs pressure onto i_rx only while it stalls.
// Reset (i_rst_n low, synchronous) returns to hunting with no result pending.
// depends on efd_pkg and efd_if
module escaped_frame_deframer_crc32 (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efd_in_if.sink    i_rx,
    efd_out_if.source o_res
);
    import efd_pkg::*;

    logic    r_seen, n_seen;
    logic    r_in_frame, n_in_frame;
    logic    r_esc, n_esc;
    t_fill   r_fill, n_fill;
    t_crc    r_crc, n_crc;
    t_byte   r_dly [TRAILER_LEN];
    t_byte   n_dly [TRAILER_LEN];

    logic    r_out_valid;
    logic    r_out_kind;
    t_byte   r_out_byte;
    t_status r_out_status;

    logic    in_rdy;
    logic    acc;
    t_byte   c;
    logic    do_push;
    logic    produce;
    logic    res_kind;
    t_byte   res_byte;
    t_status res_status;
    t_status verdict;

    assign in_rdy     = !r_out_valid || o_res.ready;
    assign i_rx.ready = in_rdy;
    assign acc        = i_rx.valid && in_rdy;
    assign c          = i_rx.rx_byte;

    // trailer holds oldest byte in the low position
    always_comb begin
        if (r_fill < TRAILER_FULL) begin
            verdict = ST_SHORT;
        end else if ({r_dly[3], r_dly[2], r_dly[1], r_dly[0]} == ~r_crc) begin
            verdict = ST_GOOD;
        end else begin
            verdict = ST_BAD_CRC;
        end
    end

    always_comb begin
        n_seen     = r_seen;
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        n_fill     = r_fill;
        n_crc      = r_crc;
        n_dly      = r_dly;
        do_push    = 1'b0;
        produce    = 1'b0;
        res_kind   = KIND_DATA;
        res_byte   = '0;
        res_status = ST_GOOD;

        if (acc) begin
            if (!r_in_frame) begin
                if (c == MARK_START && !r_seen) begin
                    n_seen = 1'b1;
                end else if (c == MARK_START) begin
                    n_seen     = 1'b0;
                    n_in_frame = 1'b1;
                    n_esc      = 1'b0;
                    n_fill     = '0;
                    n_crc      = CRC_INIT;
                end else begin
                    n_seen = 1'b0;
                end
            end else if (r_esc) begin
                n_esc   = 1'b0;
                do_push = 1'b1;
            end else if (c == MARK_ESC) begin
                n_esc = 1'b1;
            end else if (c == MARK_END || c == MARK_START) begin
                produce    = 1'b1;
                res_kind   = KIND_END;
                res_status = verdict;
                n_in_frame = 1'b0;
                n_seen     = (c == MARK_START);
            end else begin
                do_push = 1'b1;
            end
        end

        if (do_push) begin
            if (r_fill < TRAILER_FULL) begin
                n_dly[r_fill[1:0]] = c;
                n_fill             = r_fill + t_fill'(1);
            end else begin
                for (int i = 0; i < TRAILER_LEN - 1; i++) begin
                    n_dly[i] = r_dly[i + 1];
                end
                n_dly[TRAILER_LEN - 1] = c;
                n_crc    = crc32_byte(r_crc, r_dly[0]);
                produce  = 1'b1;
                res_kind = KIND_DATA;
                res_byte = r_dly[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_in_frame  <= 1'b0;
            r_esc       <= 1'b0;
            r_fill      <= '0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_seen     <= n_seen;
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_fill     <= n_fill;
            r_crc      <= n_crc;
            if (acc && produce) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly <= n_dly;
        if (acc && produce) begin
            r_out_kind   <= res_kind;
            r_out_byte   <= res_byte;
            r_out_status <= res_status;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_kind     = r_out_kind;
    assign o_res.out_byte     = r_out_byte;
    assign o_res.frame_status = r_out_status;

    // fill count never passes the trailer length
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= TRAILER_FULL)
        else $error("delay fill count out of range");

    // an unescaped end marker inside a frame returns to hunting
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_in_frame && !r_esc && c == MARK_END |=> !r_in_frame && !r_seen)
        else $error("end marker did not close the frame");

    // a frame end always yields a status result the next cycle
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_in_frame && !r_esc && (c == MARK_END || c == MARK_START)
        |=> r_out_valid && r_out_kind == KIND_END)
        else $error("frame end produced no status");

    // payload results carry a good status code and come from a full delay line
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_DATA |-> r_out_status == ST_GOOD
        && r_fill == TRAILER_FULL)
        else $error("payload result with bad status or partial delay line");

    // status results carry a zero byte
    a_status_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_END |-> r_out_byte == '0)
        else $error("status result with nonzero byte");

endmodule
